// ----- design/knps_pkg.sv -----
// Shared types, constants and the ranking function of the k-nearest-points selector.
// Used by k_nearest_points_select; no dependencies of its own.
package knps_pkg;

	localparam int MAX_K_DEFAULT = 32;
	localparam int COORD_W       = 16;
	localparam int DIST_W        = 34;
	localparam int KEEP_W        = 6;
	localparam int REG_IDX_W     = 2;
	localparam int PADDR_W       = 4;

	// register indexes on the configuration port (byte address 4*index)
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      set_end;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] near_x;
		logic signed [COORD_W-1:0] near_y;
		logic                      run_end;
	} near_out_t;

	// one stored entry: squared distance and the point
	typedef struct packed {
		logic        [DIST_W-1:0]  sq_dist;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// true when a ranks strictly before b: distance, then x, then y
	function automatic logic ranks_before(input entry_t a, input entry_t b);
		logic res;
		if (a.sq_dist != b.sq_dist) begin
			res = (a.sq_dist < b.sq_dist);
		end else if (a.x != b.x) begin
			res = (a.x < b.x);
		end else begin
			res = (a.y < b.y);
		end
		return res;
	endfunction

endpackage

// ----- design/knps_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module knps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/k_nearest_points_select.sv -----
// Top level of the k-nearest-points selector: control, distance datapath, APB registers.
// Depends on knps_pkg and on knps_ram for the sorted store of kept points.
//
// Keeps the keep_count points nearest to (origin_x, origin_y) out of a set that
// arrives one item per start pulse, and emits them best first when the item
// marked set_end has been taken in. Ranking is by exact squared distance, then x,
// then y. The kept points live in one RAM, sorted ascending; a new point is placed
// by an insertion walk from the worst entry towards the best, one RAM entry read
// and shifted per cycle. An item passes the subtract, square and sum steps, then one
// walk step per entry it moves past, and is written in its place unless it is dropped;
// the walk through the RAM read port sets how long an item takes, and no new item is
// taken before the last is through. A final item then streams its kept points out at
// one per cycle, each read passing the RAM read register and result register. Results
// appear on result for exactly one cycle, marked by strobe, and cannot be held off
// by the receiver: take every strobed item as it comes. busy is low whenever a new
// item can be taken; a strobe may still follow after busy falls. No clearing pass
// is needed after reset: entries at or beyond the fill count are never used.
module k_nearest_points_select #(
	parameter int MAX_K = knps_pkg::MAX_K_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             start,
	output logic                             busy,
	input  knps_pkg::point_in_t              point,
	output logic                             strobe,
	output knps_pkg::near_out_t              result,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [knps_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CW = $clog2(MAX_K + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_SUM,
		ST_SHIFT,
		ST_PLACE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [knps_pkg::COORD_W-1:0] origin_x_q;
	logic signed [knps_pkg::COORD_W-1:0] origin_y_q;
	logic        [knps_pkg::KEEP_W-1:0]  keep_count_q;

	// distance datapath
	knps_pkg::point_in_t                 point_q;
	logic signed [knps_pkg::COORD_W:0]   dx_q;
	logic signed [knps_pkg::COORD_W:0]   dy_q;
	logic signed [2*knps_pkg::COORD_W+1:0] sqx_full;
	logic signed [2*knps_pkg::COORD_W+1:0] sqy_full;
	logic        [2*knps_pkg::COORD_W-1:0] sqx_q;
	logic        [2*knps_pkg::COORD_W-1:0] sqy_q;
	logic        [knps_pkg::DIST_W-1:0]  dist_q;

	// insertion walk
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] pos_dec2;
	logic [CW-1:0] cnt_dec;
	logic          skip_q;
	logic          inc_q;
	logic [CW-1:0] lim;
	logic [CW-1:0] cnt_eff;
	logic          ahead;

	// emission
	logic [CW-1:0] em_idx_q;
	logic          emit_rd_s1;
	logic          last_s1;
	logic          strobe_q;
	knps_pkg::near_out_t result_q;

	// store
	knps_pkg::entry_t              new_ent;
	knps_pkg::entry_t              rd_ent;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 ram_raddr;
	logic [knps_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [knps_pkg::ENTRY_W-1:0]  ram_rdata;

	logic cfg_wr;

	knps_ram #(
		.WIDTH (knps_pkg::ENTRY_W),
		.DEPTH (MAX_K)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// effective limit: zero counts as one, saturate at the store depth
	always_comb begin
		if (keep_count_q == '0) begin
			lim = CW'(1);
		end else if ({1'b0, keep_count_q} > (knps_pkg::KEEP_W + 1)'(MAX_K)) begin
			lim = CW'(MAX_K);
		end else begin
			lim = CW'(keep_count_q);
		end
	end

	// a lowered limit cuts the held list before the next point is considered
	assign cnt_eff = (cnt_q > lim) ? lim : cnt_q;
	assign cnt_dec = cnt_eff - CW'(1);
	assign pos_dec2 = pos_q - CW'(2);

	assign new_ent.sq_dist = dist_q;
	assign new_ent.x       = point_q.point_x;
	assign new_ent.y       = point_q.point_y;
	assign rd_ent          = knps_pkg::entry_t'(ram_rdata);
	assign ahead           = knps_pkg::ranks_before(new_ent, rd_ent);

	assign sqx_full = dx_q * dx_q;
	assign sqy_full = dy_q * dy_q;

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = new_ent;
		ram_raddr = '0;
		case (state_q)
			ST_SUM: begin
				// fetch the worst held entry to start the walk
				ram_raddr = cnt_dec[AW-1:0];
			end
			ST_SHIFT: begin
				if (ahead) begin
					// move the compared entry one place down, unless it is the one dropped
					ram_we    = !skip_q;
					ram_wdata = rd_ent;
					ram_raddr = pos_dec2[AW-1:0];
				end else begin
					ram_we = !skip_q;
				end
			end
			ST_PLACE: begin
				ram_we = 1'b1;
			end
			ST_EMIT: begin
				ram_raddr = em_idx_q[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign cfg_wr = psel && penable && pwrite;

	// control, configuration and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			keep_count_q <= knps_pkg::KEEP_W'(1);
			cnt_q        <= '0;
			pos_q        <= '0;
			skip_q       <= 1'b0;
			inc_q        <= 1'b0;
			em_idx_q     <= '0;
			emit_rd_s1   <= 1'b0;
			last_s1      <= 1'b0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					knps_pkg::REG_ORIGIN_X:   origin_x_q   <= pwdata[knps_pkg::COORD_W-1:0];
					knps_pkg::REG_ORIGIN_Y:   origin_y_q   <= pwdata[knps_pkg::COORD_W-1:0];
					knps_pkg::REG_KEEP_COUNT: keep_count_q <= pwdata[knps_pkg::KEEP_W-1:0];
					default: ;
				endcase
			end

			// the read issued in an emission cycle returns in the cycle after it
			emit_rd_s1 <= (state_q == ST_EMIT);
			strobe_q   <= emit_rd_s1;
			if (emit_rd_s1) begin
				result_q.near_x  <= rd_ent.x;
				result_q.near_y  <= rd_ent.y;
				result_q.run_end <= last_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// hold the cut count; a full list starts by deciding on the drop
					cnt_q  <= cnt_eff;
					pos_q  <= cnt_eff;
					skip_q <= (cnt_eff == lim);
					inc_q  <= (cnt_eff != lim);
					if (cnt_eff == '0) begin
						state_q <= ST_PLACE;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (ahead) begin
						skip_q <= 1'b0;
						pos_q  <= pos_q - CW'(1);
						if (pos_q == CW'(1)) begin
							state_q <= ST_PLACE;
						end
					end else begin
						// a rejected point leaves the count alone
						cnt_q    <= cnt_q + CW'(inc_q && !skip_q);
						em_idx_q <= '0;
						state_q  <= point_q.set_end ? ST_EMIT : ST_IDLE;
					end
				end
				ST_PLACE: begin
					cnt_q    <= cnt_q + CW'(inc_q);
					em_idx_q <= '0;
					state_q  <= point_q.set_end ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					last_s1    <= (em_idx_q + CW'(1) == cnt_q);
					em_idx_q   <= em_idx_q + CW'(1);
					if (em_idx_q + CW'(1) == cnt_q) begin
						// empty the store for the next set
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			point_q <= point;
			dx_q    <= {point.point_x[knps_pkg::COORD_W-1], point.point_x}
				- {origin_x_q[knps_pkg::COORD_W-1], origin_x_q};
			dy_q    <= {point.point_y[knps_pkg::COORD_W-1], point.point_y}
				- {origin_y_q[knps_pkg::COORD_W-1], origin_y_q};
		end
		if (state_q == ST_SQR) begin
			// squares of 17-bit differences stay below 2^32
			sqx_q <= sqx_full[2*knps_pkg::COORD_W-1:0];
			sqy_q <= sqy_full[2*knps_pkg::COORD_W-1:0];
		end
		if (state_q == ST_SUM) begin
			dist_q <= knps_pkg::DIST_W'(sqx_q) + knps_pkg::DIST_W'(sqy_q);
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			knps_pkg::REG_ORIGIN_X:   prdata = {16'b0, origin_x_q};
			knps_pkg::REG_ORIGIN_Y:   prdata = {16'b0, origin_y_q};
			knps_pkg::REG_KEEP_COUNT: prdata = {26'b0, keep_count_q};
			default:                  prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule
